@@ rtl/core/apd_pkg.sv @@
// ----------------------------------------------------------------------------
// apd_pkg: shared definitions for the ATA PIO disk device
// Sizes of the sector store, task file register offsets, command codes,
// status bits and the structures that pass between the device modules.
// ----------------------------------------------------------------------------
package apd_pkg;

   // Sector store geometry
   localparam int SECTOR_ADDR_BITS = 10;
   localparam int WORDS_PER_SECTOR = 256;
   localparam int WORD_IDX_W       = $clog2(WORDS_PER_SECTOR);
   localparam int STORE_ADDR_W     = SECTOR_ADDR_BITS + WORD_IDX_W;
   localparam int STORE_WORDS      = 1 << STORE_ADDR_W;
   localparam int DATA_W           = 16;

   // Task file widths
   localparam int LBA_W      = 28;
   localparam int SECT_CNT_W = 9;
   localparam int CAP_W      = 11;
   localparam int EFF_W      = (SECTOR_ADDR_BITS + 1 > CAP_W) ? SECTOR_ADDR_BITS + 1 : CAP_W;

   localparam logic [CAP_W-1:0]      CAP_RESET      = CAP_W'(1024);
   localparam logic [WORD_IDX_W-1:0] WORD_LAST      = WORD_IDX_W'(WORDS_PER_SECTOR - 1);
   localparam logic [WORD_IDX_W-1:0] IDENT_CAP_LO   = WORD_IDX_W'(60);
   localparam logic [WORD_IDX_W-1:0] IDENT_CAP_HI   = WORD_IDX_W'(61);

   // Access direction
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Task file register offsets
   localparam logic [2:0] REG_DATA     = 3'd0;
   localparam logic [2:0] REG_ERROR    = 3'd1;
   localparam logic [2:0] REG_COUNT    = 3'd2;
   localparam logic [2:0] REG_LBA_LOW  = 3'd3;
   localparam logic [2:0] REG_LBA_MID  = 3'd4;
   localparam logic [2:0] REG_LBA_HIGH = 3'd5;
   localparam logic [2:0] REG_DEVICE   = 3'd6;
   localparam logic [2:0] REG_COMMAND  = 3'd7;

   // Commands
   localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
   localparam logic [7:0] CMD_READ     = 8'h20;
   localparam logic [7:0] CMD_WRITE    = 8'h30;

   // Register bits
   localparam logic [7:0] STATUS_DRDY   = 8'h40;
   localparam logic [7:0] STATUS_DRQ    = 8'h08;
   localparam logic [7:0] STATUS_ERR    = 8'h01;
   localparam logic [7:0] ERROR_ABRT    = 8'h04;
   localparam logic [7:0] DEVICE_SLAVE  = 8'h10;
   localparam logic [7:0] DEVICE_LBA_HI = 8'h0F;
   localparam logic [7:0] DEVICE_RESET  = 8'hA0;

   // Transfer phase, one-hot
   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_IDENT = 4'b0010,
      MODE_READ  = 4'b0100,
      MODE_WRITE = 4'b1000
   } mode_type;

   // One access to the sector store
   typedef struct packed {
      logic                    wr_en;
      logic [STORE_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]       wr_data;
   } store_req_type;

   // Registered response of the task file controller
   typedef struct packed {
      logic              strobe;
      logic              from_store;
      logic [DATA_W-1:0] data;
      logic              drq;
   } rsp_type;

endpackage

@@ rtl/core/apd_ram.sv @@
// ----------------------------------------------------------------------------
// apd_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module apd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/apd_clear.sv @@
// ----------------------------------------------------------------------------
// apd_clear: post-reset clearing sweep of the sector store
// Writes zero to one store word per cycle after reset and reports busy
// until every word has been written.
// ----------------------------------------------------------------------------
module apd_clear (
   input  logic                   clock,
   input  logic                   reset,
   output logic                   busy,
   output apd_pkg::store_req_type clear_req
);
   import apd_pkg::*;

   // The top bit sets once the sweep has passed the last word.
   logic [STORE_ADDR_W:0] sweep_ff;
   logic [STORE_ADDR_W:0] sweep_in;

   assign busy     = ~sweep_ff[STORE_ADDR_W];
   assign sweep_in = busy ? sweep_ff + 1'b1 : sweep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   always_comb begin
      clear_req.wr_en   = busy;
      clear_req.addr    = sweep_ff[STORE_ADDR_W-1:0];
      clear_req.wr_data = '0;
   end

endmodule

@@ rtl/core/apd_ctrl.sv @@
// ----------------------------------------------------------------------------
// apd_ctrl: task file registers and transfer sequencing
// Decodes one register access per accepted transfer, runs the command
// checks, steps the word index and addresses the sector store.
// ----------------------------------------------------------------------------
module apd_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_type,
   input  logic [2:0]                    req_reg_offset,
   input  logic [apd_pkg::DATA_W-1:0]    req_write_data,
   input  logic                          csr_write_enable,
   input  logic [apd_pkg::CAP_W-1:0]     csr_write_data,
   output apd_pkg::store_req_type        store_req,
   output apd_pkg::rsp_type              rsp
);
   import apd_pkg::*;

   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [7:0]            count_ff, count_in;
   logic [7:0]            lba_ff [3];
   logic [7:0]            lba_in [3];
   logic [7:0]            device_ff, device_in;
   logic                  err_ff, err_in;
   mode_type              mode_ff, mode_in;
   logic [WORD_IDX_W-1:0] word_idx_ff, word_idx_in;
   logic [SECT_CNT_W-1:0] sect_left_ff, sect_left_in;
   logic [LBA_W-1:0]      cur_lba_ff, cur_lba_in;
   rsp_type               rsp_ff, rsp_in;

   logic [EFF_W-1:0]      eff_cap;
   logic [31:0]           eff_cap_wide;
   logic [LBA_W-1:0]      cmd_lba;
   logic [SECT_CNT_W-1:0] cmd_count;
   logic                  out_of_range;
   logic                  drq;
   logic [7:0]            wr_byte;
   logic                  advance;
   logic [SECT_CNT_W-1:0] sect_dec;

   // Capacity is capped at the size of the store.
   always_comb begin
      if (EFF_W'(cap_ff) < (EFF_W'(1) << SECTOR_ADDR_BITS)) begin
         eff_cap = EFF_W'(cap_ff);
      end else begin
         eff_cap = EFF_W'(1) << SECTOR_ADDR_BITS;
      end
   end

   assign eff_cap_wide = 32'(eff_cap);
   assign cmd_lba      = {(device_ff[3:0] & DEVICE_LBA_HI[3:0]), lba_ff[2], lba_ff[1], lba_ff[0]};
   assign cmd_count    = (count_ff == 8'd0) ? SECT_CNT_W'(256) : SECT_CNT_W'(count_ff);
   assign out_of_range = ({1'b0, cmd_lba} + (LBA_W + 1)'(cmd_count)) > (LBA_W + 1)'(eff_cap);
   assign drq          = (mode_ff != MODE_IDLE);
   assign wr_byte      = req_write_data[7:0];
   assign sect_dec     = (sect_left_ff != '0) ? sect_left_ff - 1'b1 : sect_left_ff;

   always_comb begin
      cap_in       = csr_write_enable ? csr_write_data : cap_ff;
      count_in     = count_ff;
      lba_in       = lba_ff;
      device_in    = device_ff;
      err_in       = err_ff;
      mode_in      = mode_ff;
      word_idx_in  = word_idx_ff;
      sect_left_in = sect_left_ff;
      cur_lba_in   = cur_lba_ff;
      advance      = 1'b0;

      store_req.wr_en   = 1'b0;
      store_req.addr    = {cur_lba_ff[SECTOR_ADDR_BITS-1:0], word_idx_ff};
      store_req.wr_data = req_write_data;

      rsp_in.strobe     = accept;
      rsp_in.from_store = 1'b0;
      rsp_in.data       = '0;
      rsp_in.drq        = 1'b0;

      if (accept) begin
         if (req_type == REQ_WRITE) begin
            case (req_reg_offset)
               REG_DATA: begin
                  if (mode_ff == MODE_WRITE) begin
                     store_req.wr_en = 1'b1;
                     advance         = 1'b1;
                  end
               end
               REG_COUNT:    count_in  = wr_byte;
               REG_LBA_LOW:  lba_in[0] = wr_byte;
               REG_LBA_MID:  lba_in[1] = wr_byte;
               REG_LBA_HIGH: lba_in[2] = wr_byte;
               REG_DEVICE:   device_in = wr_byte;
               REG_COMMAND: begin
                  // A command always ends the running transfer first.
                  err_in       = 1'b0;
                  mode_in      = MODE_IDLE;
                  word_idx_in  = '0;
                  sect_left_in = '0;
                  if ((device_ff & DEVICE_SLAVE) != 8'h00) begin
                     err_in = 1'b1;
                  end else if (wr_byte == CMD_IDENTIFY) begin
                     mode_in      = MODE_IDENT;
                     sect_left_in = SECT_CNT_W'(1);
                  end else if (wr_byte != CMD_READ && wr_byte != CMD_WRITE) begin
                     err_in = 1'b1;
                  end else if (out_of_range) begin
                     err_in = 1'b1;
                  end else begin
                     cur_lba_in   = cmd_lba;
                     sect_left_in = cmd_count;
                     mode_in      = (wr_byte == CMD_READ) ? MODE_READ : MODE_WRITE;
                  end
               end
               default: ;
            endcase
         end else begin
            case (req_reg_offset)
               REG_DATA: begin
                  case (mode_ff)
                     MODE_IDENT: begin
                        if (word_idx_ff == IDENT_CAP_LO) begin
                           rsp_in.data = eff_cap_wide[15:0];
                        end else if (word_idx_ff == IDENT_CAP_HI) begin
                           rsp_in.data = eff_cap_wide[31:16];
                        end
                        advance = 1'b1;
                     end
                     MODE_READ: begin
                        rsp_in.from_store = 1'b1;
                        advance           = 1'b1;
                     end
                     default: ;
                  endcase
               end
               REG_ERROR:    rsp_in.data = err_ff ? DATA_W'(ERROR_ABRT) : '0;
               REG_COUNT:    rsp_in.data = DATA_W'(count_ff);
               REG_LBA_LOW:  rsp_in.data = DATA_W'(lba_ff[0]);
               REG_LBA_MID:  rsp_in.data = DATA_W'(lba_ff[1]);
               REG_LBA_HIGH: rsp_in.data = DATA_W'(lba_ff[2]);
               REG_DEVICE:   rsp_in.data = DATA_W'(device_ff);
               default: begin
                  rsp_in.data = DATA_W'(STATUS_DRDY | (drq ? STATUS_DRQ : 8'h00)
                                        | (err_ff ? STATUS_ERR : 8'h00));
               end
            endcase
         end
      end

      // Step to the next word; the sector boundary moves the LBA on.
      if (advance) begin
         if (word_idx_ff == WORD_LAST) begin
            word_idx_in  = '0;
            cur_lba_in   = cur_lba_ff + 1'b1;
            sect_left_in = sect_dec;
            if (sect_dec == '0) begin
               mode_in = MODE_IDLE;
            end
         end else begin
            word_idx_in = word_idx_ff + 1'b1;
         end
      end

      rsp_in.drq = (mode_in != MODE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         count_ff      <= '0;
         lba_ff        <= '{default: 8'h00};
         device_ff     <= DEVICE_RESET;
         err_ff        <= 1'b0;
         mode_ff       <= MODE_IDLE;
         word_idx_ff   <= '0;
         sect_left_ff  <= '0;
         cur_lba_ff    <= '0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         lba_ff        <= lba_in;
         device_ff     <= device_in;
         err_ff        <= err_in;
         mode_ff       <= mode_in;
         word_idx_ff   <= word_idx_in;
         sect_left_ff  <= sect_left_in;
         cur_lba_ff    <= cur_lba_in;
         rsp_ff.strobe <= rsp_in.strobe;
      end
      rsp_ff.from_store <= rsp_in.from_store;
      rsp_ff.data       <= rsp_in.data;
      rsp_ff.drq        <= rsp_in.drq;
   end

   assign rsp = rsp_ff;

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.strobe |-> $past(accept))
      else $error("response without an accepted access");

   a_store_write_in_write_mode: assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> (mode_ff == MODE_WRITE))
      else $error("store written outside a write transfer");

   a_store_read_needs_read_mode: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_in.from_store) |-> (mode_ff == MODE_READ && drq))
      else $error("store read outside a read transfer");

   a_active_transfer_has_sectors: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (sect_left_ff != '0))
      else $error("transfer active with no sectors left");

endmodule

@@ rtl/core/ata_pio_disk_device.sv @@
// ----------------------------------------------------------------------------
// ata_pio_disk_device: device side of an ATA PIO task file, LBA28, master only
// Takes one task file register access per transfer and answers each with
// one response; IDENTIFY, READ SECTORS and WRITE SECTORS move 256-word
// sectors through the data port to and from an internal sector store.
// ----------------------------------------------------------------------------
//
//   Channel   | Handshake                  | Payload
//   ----------+----------------------------+-----------------------------------
//   request   | start in, busy out         | req_type, req_reg_offset,
//             |                            | req_write_data
//   response  | rsp_strobe out, one cycle  | rsp_read_data, rsp_data_request
//   csr       | csr_write_enable in        | csr_write_data (capacity)
//
// A request transfer is taken at every edge where start is high and busy is
// low, so one access per cycle is sustained; its response appears in the
// next cycle, since a data port read needs the registered store read.
// After reset busy stays high while every word of the store is swept to
// zero; capacity writes are taken during the sweep.
// The response cannot be stalled: rsp_strobe lasts exactly one cycle.
//
module ata_pio_disk_device (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic [2:0]                   req_reg_offset,
   input  logic [apd_pkg::DATA_W-1:0]   req_write_data,
   output logic                         rsp_strobe,
   output logic [apd_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                         rsp_data_request,
   input  logic                         csr_write_enable,
   input  logic [apd_pkg::CAP_W-1:0]    csr_write_data
);
   import apd_pkg::*;

   logic          clearing;
   logic          accept;
   store_req_type clear_req;
   store_req_type ctrl_req;
   store_req_type ram_req;
   rsp_type       ctrl_rsp;
   logic [DATA_W-1:0] ram_rd_data;

   // The clearing sweep owns the store port until every word is zero.
   apd_clear u_clear (
      .clock     (clock),
      .reset     (reset),
      .busy      (clearing),
      .clear_req (clear_req)
   );

   assign busy   = clearing;
   assign accept = start & ~clearing;

   // Task file registers and transfer control. The store address is formed
   // from the latched LBA and the word index, so a data port access reads or
   // writes the store in the same cycle as it is accepted.
   apd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_type         (req_type),
      .req_reg_offset   (req_reg_offset),
      .req_write_data   (req_write_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .store_req        (ctrl_req),
      .rsp              (ctrl_rsp)
   );

   assign ram_req = clearing ? clear_req : ctrl_req;

   // Sector store: one word per entry, indexed by LBA and word index. A
   // write lands at the accepting edge, so a later read always sees it.
   apd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .addr    (ram_req.addr),
      .wr_data (ram_req.wr_data),
      .rd_data (ram_rd_data)
   );

   // A data port read during a read transfer takes its word from the store's
   // registered output; every other response is already in the controller's
   // response register.
   assign rsp_strobe       = ctrl_rsp.strobe;
   assign rsp_read_data    = ctrl_rsp.from_store ? ram_rd_data : ctrl_rsp.data;
   assign rsp_data_request = ctrl_rsp.drq;

endmodule
